// ===== rtl/vp8l_cld_pkg.sv =====
// Shared types, constants and tables for the code length decoder.
package vp8l_cld_pkg;

  localparam int unsigned CodeLengthCodes = 19;
  localparam int unsigned MaxAlphabet     = 2328;

  localparam logic [4:0] ClcOrder [CodeLengthCodes] = '{
    5'd17, 5'd18, 5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd16, 5'd6,
    5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15
  };

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusOverrun  = 2'd1;
  localparam logic [1:0] StatusMaxSym   = 2'd2;
  localparam logic [1:0] StatusNoCode   = 2'd3;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_COUNT = 6'b000010,
    PH_CLC   = 6'b000100,
    PH_FLAG  = 6'b001000,
    PH_SYM   = 6'b010000,
    PH_EXTRA = 6'b100000
  } phase_e;

  typedef struct packed {
    logic take;
    logic build_start;
    logic count_en;
    logic place_start;
    logic place_en;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic need_build;
    logic result;
    logic sweep_last;
  } sts_t;

  function automatic logic [2:0] extra_width(input logic [1:0] kind);
    unique case (kind)
      2'd0:    extra_width = 3'd2;
      2'd1:    extra_width = 3'd3;
      default: extra_width = 3'd7;
    endcase
  endfunction

  function automatic logic [7:0] extra_base(input logic [1:0] kind);
    unique case (kind)
      2'd0:    extra_base = 8'd3;
      2'd1:    extra_base = 8'd3;
      default: extra_base = 8'd11;
    endcase
  endfunction

endpackage

// ===== rtl/vp8l_code_length_decoder.sv =====
// Top level of the lossless prefix-code code length decoder.
//
//  channel  direction  handshake                  payload
//  in       input      in_valid_i / in_stall_o    bit_req_i, first_i
//  out      output     out_valid_o / out_stall_i  start_symbol_o, code_length_o,
//                                                 repeat_count_o, last_o, status_o
//  cfg      input      cfg_we_i                   cfg_wdata_i (alphabet size)
//
// A bit that gives a run holds its result in the output register while out_stall_i
// is high.
// The max-symbol flag bit with value 0 starts the code build: two sweeps over the
// 19 code-length-code entries plus a final check, before the next bit is taken.
// Reset sets the alphabet size to 256 and leaves the decoder idle until first_i.
// While a result is stalled, no input bit is taken.
module vp8l_code_length_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        bit_req_i,
  input  logic        first_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] start_symbol_o,
  output logic [3:0]  code_length_o,
  output logic [7:0]  repeat_count_o,
  output logic        last_o,
  output logic [1:0]  status_o,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i
);
  import vp8l_cld_pkg::*;

  cmd_t cmd;
  sts_t sts;

  vp8l_cld_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  vp8l_cld_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .bit_req_i      (bit_req_i),
    .first_i        (first_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start_symbol_o (start_symbol_o),
    .code_length_o  (code_length_o),
    .repeat_count_o (repeat_count_o),
    .last_o         (last_o),
    .status_o       (status_o)
  );

endmodule

// ===== rtl/vp8l_cld_ctrl.sv =====
// Controller: handshakes, table build sequencing and result hold.
module vp8l_cld_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  vp8l_cld_pkg::sts_t  sts_i,
  output vp8l_cld_pkg::cmd_t  cmd_o
);
  import vp8l_cld_pkg::*;

  typedef enum logic [4:0] {
    ST_ACCEPT = 5'b00001,
    ST_COUNT  = 5'b00010,
    ST_PLACE  = 5'b00100,
    ST_FINISH = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o  = (state_q != ST_ACCEPT);
  assign out_valid_o = (state_q == ST_EMIT);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_ACCEPT: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (sts_i.need_build) begin
            cmd_o.build_start = 1'b1;
            state_d = ST_COUNT;
          end else if (sts_i.result) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_COUNT: begin
        cmd_o.count_en = 1'b1;
        if (sts_i.sweep_last) begin
          cmd_o.place_start = 1'b1;
          state_d = ST_PLACE;
        end
      end
      ST_PLACE: begin
        cmd_o.place_en = 1'b1;
        if (sts_i.sweep_last) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d = sts_i.result ? ST_EMIT : ST_ACCEPT;
      end
      ST_EMIT: begin
        if (!out_stall_i) state_d = ST_ACCEPT;
      end
      default: state_d = ST_ACCEPT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCEPT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/vp8l_cld_dp.sv =====
// Datapath: field assembly, code-length code build and canonical decode.
module vp8l_cld_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vp8l_cld_pkg::cmd_t  cmd_i,
  output vp8l_cld_pkg::sts_t  sts_o,
  input  logic                bit_req_i,
  input  logic                first_i,
  input  logic                cfg_we_i,
  input  logic [11:0]         cfg_wdata_i,
  output logic [11:0]         start_symbol_o,
  output logic [3:0]          code_length_o,
  output logic [7:0]          repeat_count_o,
  output logic                last_o,
  output logic [1:0]          status_o
);
  import vp8l_cld_pkg::*;

  phase_e      phase_q, phase_d;
  logic [6:0]  acc_q, acc_d;
  logic [2:0]  bc_q, bc_d;
  logic [4:0]  entries_q, entries_d;
  logic [4:0]  clc_idx_q, clc_idx_d;
  logic [2:0]  clc_q [CodeLengthCodes];
  logic [4:0]  sorted_q [CodeLengthCodes];
  logic [4:0]  counts_q [8];
  logic [4:0]  fill_q [8];
  logic [4:0]  ncodes_q, ncodes_d;
  logic [6:0]  code_q, code_d;
  logic [2:0]  code_len_q, code_len_d;
  logic [8:0]  first_code_q, first_code_d;
  logic [4:0]  idx_q, idx_d;
  logic [11:0] done_q, done_d;
  logic [3:0]  prev_q, prev_d;
  logic [1:0]  kind_q, kind_d;
  logic [11:0] alpha_q;
  logic [4:0]  sweep_q;
  logic [11:0] o_start_q, o_start_d;
  logic [3:0]  o_len_q, o_len_d;
  logic [7:0]  o_rep_q, o_rep_d;
  logic        o_last_q, o_last_d;
  logic [1:0]  o_status_q, o_status_d;

  logic        clc_clr, clc_we;
  logic [4:0]  clc_waddr;
  logic [2:0]  clc_wdata;

  phase_e      ph;
  logic [6:0]  acc, acc_t;
  logic [2:0]  bc, bc_t;
  logic        sym_ok, do_extra, emit, err, res;
  logic [4:0]  sym;
  logic [1:0]  xk, err_code;
  logic [6:0]  xacc;
  logic [2:0]  xbc, dl;
  logic [3:0]  em_len;
  logic [7:0]  em_rep;
  logic [12:0] run_end;
  logic [8:0]  dc, diff;
  logic [4:0]  dcnt, dpos;

  logic [4:0]  off [8];
  logic [4:0]  total;
  logic [11:0] kraft;
  logic [2:0]  sw_len;
  logic [4:0]  place_pos;

  always_comb begin
    off[0] = '0;
    off[1] = '0;
    kraft  = '0;
    for (int l = 1; l < 7; l++) begin
      off[l+1] = off[l] + counts_q[l];
    end
    for (int l = 1; l < 8; l++) begin
      kraft = kraft + (12'(counts_q[l]) << (7 - l));
    end
    total = off[7] + counts_q[7];
  end

  assign sw_len    = clc_q[sweep_q];
  assign place_pos = off[sw_len] + fill_q[sw_len];

  always_comb begin
    phase_d      = phase_q;
    acc_d        = acc_q;
    bc_d         = bc_q;
    entries_d    = entries_q;
    clc_idx_d    = clc_idx_q;
    ncodes_d     = ncodes_q;
    code_d       = code_q;
    code_len_d   = code_len_q;
    first_code_d = first_code_q;
    idx_d        = idx_q;
    done_d       = done_q;
    prev_d       = prev_q;
    kind_d       = kind_q;
    o_start_d    = o_start_q;
    o_len_d      = o_len_q;
    o_rep_d      = o_rep_q;
    o_last_d     = o_last_q;
    o_status_d   = o_status_q;
    clc_clr      = 1'b0;
    clc_we       = 1'b0;
    clc_waddr    = '0;
    clc_wdata    = '0;
    sym_ok       = 1'b0;
    sym          = '0;
    do_extra     = 1'b0;
    xk           = kind_q;
    xacc         = '0;
    xbc          = '0;
    emit         = 1'b0;
    em_len       = '0;
    em_rep       = '0;
    err          = 1'b0;
    err_code     = StatusOk;
    run_end      = '0;
    sts_o        = '0;

    ph    = first_i ? PH_COUNT : phase_q;
    acc   = first_i ? 7'd0 : acc_q;
    bc    = first_i ? 3'd0 : bc_q;
    acc_t = acc | (7'(bit_req_i) << bc);
    bc_t  = bc + 3'd1;

    dl    = code_len_q + 3'd1;
    dc    = {2'b00, code_q[5:0], bit_req_i};
    dcnt  = counts_q[dl];
    diff  = dc - first_code_q;
    dpos  = idx_q + diff[4:0];

    if (cmd_i.take) begin
      if (first_i) begin
        entries_d    = '0;
        clc_idx_d    = '0;
        clc_clr      = 1'b1;
        ncodes_d     = '0;
        code_d       = '0;
        code_len_d   = '0;
        first_code_d = '0;
        idx_d        = '0;
        done_d       = '0;
        prev_d       = 4'd8;
        kind_d       = '0;
        phase_d      = PH_COUNT;
      end
      unique case (ph)
        PH_IDLE: ;
        PH_COUNT: begin
          acc_d = acc_t;
          bc_d  = bc_t;
          if (bc_t == 3'd4) begin
            entries_d = 5'(acc_t[3:0]) + 5'd4;
            clc_idx_d = '0;
            acc_d     = '0;
            bc_d      = '0;
            phase_d   = PH_CLC;
          end
        end
        PH_CLC: begin
          acc_d = acc_t;
          bc_d  = bc_t;
          if (bc_t == 3'd3) begin
            if (clc_idx_q < 5'(CodeLengthCodes)) begin
              clc_we    = 1'b1;
              clc_waddr = ClcOrder[clc_idx_q];
              clc_wdata = acc_t[2:0];
              clc_idx_d = clc_idx_q + 5'd1;
            end
            if (entries_q != 5'd0) entries_d = entries_q - 5'd1;
            acc_d = '0;
            bc_d  = '0;
            if (entries_q <= 5'd1) phase_d = PH_FLAG;
          end
        end
        PH_FLAG: begin
          if (bit_req_i) begin
            err      = 1'b1;
            err_code = StatusMaxSym;
          end else begin
            sts_o.need_build = 1'b1;
          end
        end
        PH_SYM: begin
          if (ncodes_q == 5'd1) begin
            sym_ok = 1'b1;
            sym    = sorted_q[0];
          end else if (dc >= first_code_q && diff < 9'(dcnt)
                       && dpos < 5'(CodeLengthCodes)) begin
            sym_ok = 1'b1;
            sym    = sorted_q[dpos];
          end else if (dl == 3'd7) begin
            err      = 1'b1;
            err_code = StatusNoCode;
          end else begin
            code_d       = dc[6:0];
            code_len_d   = dl;
            idx_d        = idx_q + dcnt;
            first_code_d = (first_code_q + 9'(dcnt)) << 1;
          end
          if (sym_ok) begin
            code_d       = '0;
            code_len_d   = '0;
            first_code_d = '0;
            idx_d        = '0;
            if (sym < 5'd16) begin
              emit   = 1'b1;
              em_len = sym[3:0];
              em_rep = 8'd1;
              if (sym[3:0] != 4'd0) prev_d = sym[3:0];
            end else begin
              kind_d  = 2'(sym - 5'd16);
              phase_d = PH_EXTRA;
              acc_d   = '0;
              bc_d    = '0;
              if (ncodes_q == 5'd1) begin
                do_extra = 1'b1;
                xk       = 2'(sym - 5'd16);
                xacc     = 7'(bit_req_i);
                xbc      = 3'd1;
              end
            end
          end
        end
        PH_EXTRA: begin
          do_extra = 1'b1;
          xk       = kind_q;
          xacc     = acc_t;
          xbc      = bc_t;
        end
        default: phase_d = PH_IDLE;
      endcase

      if (do_extra) begin
        acc_d = xacc;
        bc_d  = xbc;
        if (xbc >= extra_width(xk)) begin
          emit       = 1'b1;
          em_rep     = extra_base(xk) + 8'(xacc);
          em_len     = (xk == 2'd0) ? prev_q : 4'd0;
          acc_d      = '0;
          bc_d       = '0;
          phase_d    = PH_SYM;
          code_d     = '0;
          code_len_d = '0;
        end
      end
    end

    if (cmd_i.finish) begin
      ncodes_d = total;
      if (total == 5'd0 || (total != 5'd1 && kraft != 12'd128)) begin
        err      = 1'b1;
        err_code = StatusNoCode;
      end else begin
        phase_d      = PH_SYM;
        code_d       = '0;
        code_len_d   = '0;
        first_code_d = '0;
        idx_d        = '0;
      end
    end

    if (emit) begin
      run_end   = {1'b0, done_q} + 13'(em_rep);
      o_start_d = done_q;
      o_len_d   = em_len;
      o_rep_d   = em_rep;
      if (run_end > {1'b0, alpha_q}) begin
        o_last_d   = 1'b1;
        o_status_d = StatusOverrun;
        phase_d    = PH_IDLE;
      end else begin
        done_d     = run_end[11:0];
        o_status_d = StatusOk;
        o_last_d   = (run_end == {1'b0, alpha_q});
        if (run_end == {1'b0, alpha_q}) phase_d = PH_IDLE;
      end
    end

    if (err) begin
      o_start_d  = '0;
      o_len_d    = '0;
      o_rep_d    = '0;
      o_last_d   = 1'b1;
      o_status_d = err_code;
      phase_d    = PH_IDLE;
    end

    res              = emit | err;
    sts_o.result     = res;
    sts_o.sweep_last = (sweep_q == 5'(CodeLengthCodes - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      acc_q        <= '0;
      bc_q         <= '0;
      entries_q    <= '0;
      clc_idx_q    <= '0;
      ncodes_q     <= '0;
      code_q       <= '0;
      code_len_q   <= '0;
      first_code_q <= '0;
      idx_q        <= '0;
      done_q       <= '0;
      prev_q       <= 4'd8;
      kind_q       <= '0;
      alpha_q      <= 12'd256;
      sweep_q      <= '0;
      for (int i = 0; i < CodeLengthCodes; i++) clc_q[i] <= '0;
      for (int i = 0; i < 8; i++) begin
        counts_q[i] <= '0;
        fill_q[i]   <= '0;
      end
    end else begin
      phase_q      <= phase_d;
      acc_q        <= acc_d;
      bc_q         <= bc_d;
      entries_q    <= entries_d;
      clc_idx_q    <= clc_idx_d;
      ncodes_q     <= ncodes_d;
      code_q       <= code_d;
      code_len_q   <= code_len_d;
      first_code_q <= first_code_d;
      idx_q        <= idx_d;
      done_q       <= done_d;
      prev_q       <= prev_d;
      kind_q       <= kind_d;
      if (cfg_we_i) begin
        alpha_q <= ({1'b0, cfg_wdata_i} > 13'(MaxAlphabet)) ?
                   12'(MaxAlphabet) : cfg_wdata_i;
      end
      if (clc_clr) begin
        for (int i = 0; i < CodeLengthCodes; i++) clc_q[i] <= '0;
      end else if (clc_we) begin
        clc_q[clc_waddr] <= clc_wdata;
      end
      if (cmd_i.build_start) begin
        sweep_q <= '0;
        for (int i = 0; i < 8; i++) begin
          counts_q[i] <= '0;
          fill_q[i]   <= '0;
        end
      end else if (cmd_i.count_en) begin
        sweep_q <= cmd_i.place_start ? 5'd0 : sweep_q + 5'd1;
        if (sw_len != 3'd0) counts_q[sw_len] <= counts_q[sw_len] + 5'd1;
      end else if (cmd_i.place_en) begin
        sweep_q <= sweep_q + 5'd1;
        if (sw_len != 3'd0) fill_q[sw_len] <= fill_q[sw_len] + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.place_en && sw_len != 3'd0 && place_pos < 5'(CodeLengthCodes)) begin
      sorted_q[place_pos] <= sweep_q;
    end
    if (res) begin
      o_start_q  <= o_start_d;
      o_len_q    <= o_len_d;
      o_rep_q    <= o_rep_d;
      o_last_q   <= o_last_d;
      o_status_q <= o_status_d;
    end
  end

  assign start_symbol_o = o_start_q;
  assign code_length_o  = o_len_q;
  assign repeat_count_o = o_rep_q;
  assign last_o         = o_last_q;
  assign status_o       = o_status_q;

endmodule
